### sv/lswc_pkg.sv
// Shared constants for the line segment window clipper.
// No dependencies; imported by the top level.
package lswc_pkg;

  // Default coordinate width (signed fixed point, fraction bits do not affect the datapath).
  localparam int unsigned COORD_BITS_DEF = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd3;

endpackage

### sv/line_segment_window_clip_top.sv
// Line segment window clipper top level: configuration registers, pipeline, output skid.
// Depends on lswc_pkg, lswc_axis and lswc_div.

// Clips one segment per request to the window [origin, origin + extent] in signed fixed point.
// A new request is accepted every cycle while in_stall_o is low; each request passes the entry
// register, the two chained clip passes and the result register, and each clip pass runs one
// restoring divider that resolves one quotient bit per pipeline stage for both of its dividends.
// The x pass runs first, then the y pass; a segment whose endpoints both lie beyond the same
// side in either pass is reported with visible low and its input endpoints unchanged.
// The whole pipeline advances together; in_stall_o is a register that rises only when the
// result register and its skid stage are both full, so out_stall_i never reaches the input
// side combinationally. Write configuration only while no request is in flight; a write to
// an index beyond the four registers is ignored.
module line_segment_window_clip_top #(
  parameter int unsigned COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_BITS-1:0]     start_x_i,
  input  logic signed [COORD_BITS-1:0]     start_y_i,
  input  logic signed [COORD_BITS-1:0]     end_x_i,
  input  logic signed [COORD_BITS-1:0]     end_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             visible_o,
  output logic signed [COORD_BITS-1:0]     out_start_x_o,
  output logic signed [COORD_BITS-1:0]     out_start_y_o,
  output logic signed [COORD_BITS-1:0]     out_end_x_o,
  output logic signed [COORD_BITS-1:0]     out_end_y_o
);

  import lswc_pkg::*;

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned R = COORD_BITS + 1;

  typedef struct packed {
    logic [W-1:0] sx;
    logic [W-1:0] sy;
    logic [W-1:0] ex;
    logic [W-1:0] ey;
  } raw_t;

  typedef struct packed {
    logic         vis;
    logic [W-1:0] sx;
    logic [W-1:0] sy;
    logic [W-1:0] ex;
    logic [W-1:0] ey;
  } res_t;

  // Window registers.
  logic signed [W-1:0] origin_x_q, origin_y_q;
  logic [W-2:0]        extent_x_q, extent_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      extent_x_q <= '0;
      extent_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_EXTENT_X: extent_x_q <= cfg_data_i[W-2:0];
        CFG_EXTENT_Y: extent_y_q <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold every stage while the skid stage is occupied.
  logic skid_full_q;
  logic en;

  assign en         = ~skid_full_q;
  assign in_stall_o = skid_full_q;

  // Entry stage: register the request and make it window-relative.
  logic                s0_valid_q;
  raw_t                s0_raw_q;
  logic signed [R-1:0] s0_ax_q, s0_ay_q, s0_bx_q, s0_by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_raw_q <= '{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i};
      s0_ax_q  <= R'(start_x_i) - R'(origin_x_q);
      s0_ay_q  <= R'(start_y_i) - R'(origin_y_q);
      s0_bx_q  <= R'(end_x_i) - R'(origin_x_q);
      s0_by_q  <= R'(end_y_i) - R'(origin_y_q);
    end
  end

  // Clip in x: the clipped coordinate is x, y moves along the line.
  logic                x_valid, x_rej;
  logic signed [R-1:0] x_ax, x_ay, x_bx, x_by;
  raw_t                x_raw;

  lswc_axis #(
    .CW     (W),
    .SIDE_W ($bits(raw_t))
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .lim_i   (extent_x_q),
    .c0_i    (s0_ax_q),
    .o0_i    (s0_ay_q),
    .c1_i    (s0_bx_q),
    .o1_i    (s0_by_q),
    .side_i  (s0_raw_q),
    .valid_o (x_valid),
    .c0_o    (x_ax),
    .o0_o    (x_ay),
    .c1_o    (x_bx),
    .o1_o    (x_by),
    .rej_o   (x_rej),
    .side_o  (x_raw)
  );

  // Clip in y: roles swap, x moves along the line.
  logic                y_valid, y_rej;
  logic signed [R-1:0] y_ax, y_ay, y_bx, y_by;
  logic [$bits(raw_t):0] y_side;
  raw_t                y_raw;
  logic                y_xrej;

  lswc_axis #(
    .CW     (W),
    .SIDE_W ($bits(raw_t) + 1)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x_valid),
    .lim_i   (extent_y_q),
    .c0_i    (x_ay),
    .o0_i    (x_ax),
    .c1_i    (x_by),
    .o1_i    (x_bx),
    .side_i  ({x_rej, x_raw}),
    .valid_o (y_valid),
    .c0_o    (y_ay),
    .o0_o    (y_ax),
    .c1_o    (y_by),
    .o1_o    (y_bx),
    .rej_o   (y_rej),
    .side_o  (y_side)
  );

  assign y_xrej = y_side[$bits(raw_t)];
  assign y_raw  = raw_t'(y_side[$bits(raw_t)-1:0]);

  // Shift back to absolute coordinates, or pass the request through when rejected.
  res_t fin;

  always_comb begin
    fin.vis = ~y_xrej & ~y_rej;
    if (fin.vis) begin
      fin.sx = y_ax[W-1:0] + origin_x_q;
      fin.sy = y_ay[W-1:0] + origin_y_q;
      fin.ex = y_bx[W-1:0] + origin_x_q;
      fin.ey = y_by[W-1:0] + origin_y_q;
    end else begin
      fin.sx = y_raw.sx;
      fin.sy = y_raw.sy;
      fin.ex = y_raw.ex;
      fin.ey = y_raw.ey;
    end
  end

  // Result register with one skid entry behind it.
  logic out_valid_q, out_valid_d, skid_full_d;
  logic out_load, skid_load, out_from_skid, take;
  res_t out_q, skid_q;

  assign take = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_full_d   = skid_full_q;
    out_load      = 1'b0;
    skid_load     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_full_q) begin
      // Pipeline is frozen; drain the skid entry once the result is taken.
      if (take) begin
        out_load      = 1'b1;
        out_from_skid = 1'b1;
        skid_full_d   = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_load    = 1'b1;
      out_valid_d = y_valid;
    end else if (y_valid) begin
      skid_load   = 1'b1;
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_from_skid ? skid_q : fin;
    end
    if (skid_load) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign visible_o     = out_q.vis;
  assign out_start_x_o = out_q.sx;
  assign out_start_y_o = out_q.sy;
  assign out_end_x_o   = out_q.ex;
  assign out_end_y_o   = out_q.ey;

endmodule

### sv/lswc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two dividends sharing one divisor.
// Standalone; instantiated by lswc_axis.
module lswc_div #(
  parameter int unsigned DW     = 34,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [1:0][2*DW-1:0]       dividend_i,
  input  logic [DW-1:0]              divisor_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [1:0][DW-1:0]         quot_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic [DW-1:0]            v_q, v_d;
  logic [DW-1:0]            dvs_q [DW];
  logic [DW-1:0]            dvs_d [DW];
  logic [1:0][DW-1:0]       rem_q [DW];
  logic [1:0][DW-1:0]       rem_d [DW];
  logic [1:0][DW-1:0]       quo_q [DW];
  logic [1:0][DW-1:0]       quo_d [DW];
  logic [1:0][DW-1:0]       low_q [DW];
  logic [1:0][DW-1:0]       low_d [DW];
  logic [SIDE_W-1:0]        sd_q  [DW];
  logic [SIDE_W-1:0]        sd_d  [DW];

  // Stage k resolves quotient bit DW-1-k; the high half of the dividend is below the divisor.
  always_comb begin
    logic [1:0][DW-1:0] cr, cq, cl;
    logic [DW-1:0]      cd;
    logic [SIDE_W-1:0]  cs;
    logic               cv;
    logic [DW+1:0]      diff;
    logic               bt;
    for (int k = 0; k < DW; k++) begin
      if (k == 0) begin
        for (int l = 0; l < 2; l++) begin
          cr[l] = dividend_i[l][2*DW-1:DW];
          cl[l] = dividend_i[l][DW-1:0];
        end
        cq = '0;
        cd = divisor_i;
        cs = side_i;
        cv = valid_i;
      end else begin
        cr = rem_q[k-1];
        cl = low_q[k-1];
        cq = quo_q[k-1];
        cd = dvs_q[k-1];
        cs = sd_q[k-1];
        cv = v_q[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        bt   = cl[l][DW-1-k];
        diff = {1'b0, cr[l], bt} - {2'b00, cd};
        quo_d[k][l] = cq[l];
        quo_d[k][l][DW-1-k] = ~diff[DW+1];
        if (!diff[DW+1]) begin
          rem_d[k][l] = diff[DW-1:0];
        end else begin
          rem_d[k][l] = {cr[l][DW-2:0], bt};
        end
      end
      low_d[k] = cl;
      dvs_d[k] = cd;
      sd_d[k]  = cs;
      v_d[k]   = cv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DW; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        low_q[k] <= low_d[k];
        dvs_q[k] <= dvs_d[k];
        sd_q[k]  <= sd_d[k];
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign quot_o  = quo_q[DW-1];
  assign side_o  = sd_q[DW-1];

endmodule

### sv/lswc_axis.sv
// One clipping pass against [0, limit] on one axis, moving the other coordinate along the line.
// Uses lswc_div for the two pipelined adjustments.
module lswc_axis #(
  parameter int unsigned CW     = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [CW-2:0]         lim_i,
  input  logic signed [CW:0]    c0_i,
  input  logic signed [CW:0]    o0_i,
  input  logic signed [CW:0]    c1_i,
  input  logic signed [CW:0]    o1_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic signed [CW:0]    c0_o,
  output logic signed [CW:0]    o0_o,
  output logic signed [CW:0]    c1_o,
  output logic signed [CW:0]    o1_o,
  output logic                  rej_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned R = CW + 1;
  localparam int unsigned D = CW + 2;

  typedef struct packed {
    logic                m0;
    logic                m1;
    logic                n0;
    logic                n1;
    logic                rej;
    logic signed [R-1:0] c0;
    logic signed [R-1:0] c1;
    logic signed [R-1:0] o0;
    logic signed [R-1:0] o1;
    logic [SIDE_W-1:0]   side;
  } ctl_t;

  localparam int unsigned CTL_W = $bits(ctl_t);

  // Setup stage: classify endpoints, take differences and boundary offsets.
  logic signed [R-1:0] lim_s;
  logic                lo0, hi0, lo1, hi1;
  ctl_t                a_d, a_q;
  logic signed [D-1:0] dc_d, dn_d, b0_d, b1_d;
  logic signed [D-1:0] dc_q, dn_q, b0_q, b1_q;
  logic                a_valid_q;

  assign lim_s = $signed({2'b00, lim_i});
  assign lo0   = c0_i[R-1];
  assign lo1   = c1_i[R-1];
  assign hi0   = c0_i > lim_s;
  assign hi1   = c1_i > lim_s;

  always_comb begin
    dc_d = D'(c1_i) - D'(c0_i);
    dn_d = D'(o1_i) - D'(o0_i);
    b0_d = lo0 ? -D'(c0_i) : D'(lim_s) - D'(c0_i);
    b1_d = lo1 ? -D'(c1_i) : D'(lim_s) - D'(c1_i);
    a_d.m0   = lo0 | hi0;
    a_d.m1   = lo1 | hi1;
    a_d.n0   = 1'b0;
    a_d.n1   = 1'b0;
    a_d.rej  = (lo0 & lo1) | (hi0 & hi1);
    a_d.c0   = lo0 ? '0 : (hi0 ? lim_s : c0_i);
    a_d.c1   = lo1 ? '0 : (hi1 ? lim_s : c1_i);
    a_d.o0   = o0_i;
    a_d.o1   = o1_i;
    a_d.side = side_i;
  end

  // Product stage: magnitudes and exact double-width products.
  logic [D-1:0]        mdn, mdc, mb0, mb1;
  logic [1:0][2*D-1:0] prod_d, prod_q;
  logic [D-1:0]        ad_q;
  ctl_t                b_d, b_q;
  logic                b_valid_q;

  always_comb begin
    mdn = dn_q[D-1] ? D'(-dn_q) : D'(dn_q);
    mdc = dc_q[D-1] ? D'(-dc_q) : D'(dc_q);
    mb0 = b0_q[D-1] ? D'(-b0_q) : D'(b0_q);
    mb1 = b1_q[D-1] ? D'(-b1_q) : D'(b1_q);
    prod_d[0] = (2*D)'(mdn) * (2*D)'(mb0);
    prod_d[1] = (2*D)'(mdn) * (2*D)'(mb1);
    b_d    = a_q;
    b_d.n0 = dn_q[D-1] ^ b0_q[D-1] ^ dc_q[D-1];
    b_d.n1 = dn_q[D-1] ^ b1_q[D-1] ^ dc_q[D-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      dc_q   <= dc_d;
      dn_q   <= dn_d;
      b0_q   <= b0_d;
      b1_q   <= b1_d;
      b_q    <= b_d;
      prod_q <= prod_d;
      ad_q   <= mdc;
    end
  end

  // Divide stage.
  logic               dv_valid;
  logic [1:0][D-1:0]  dv_quot;
  logic [CTL_W-1:0]   dv_side;
  ctl_t               dv_ctl;

  lswc_div #(
    .DW     (D),
    .SIDE_W (CTL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (b_valid_q),
    .dividend_i (prod_q),
    .divisor_i  (ad_q),
    .side_i     (b_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  assign dv_ctl = ctl_t'(dv_side);

  // Apply stage: move the other coordinate of each clipped endpoint.
  logic signed [D-1:0] s0, s1;
  logic signed [R-1:0] o0_d, o1_d;
  logic signed [R-1:0] c0_q, c1_q, o0_q, o1_q;
  logic                rej_q, c_valid_q;
  logic [SIDE_W-1:0]   side_q;

  always_comb begin
    s0   = dv_ctl.n0 ? -$signed(dv_quot[0]) : $signed(dv_quot[0]);
    s1   = dv_ctl.n1 ? -$signed(dv_quot[1]) : $signed(dv_quot[1]);
    o0_d = dv_ctl.m0 ? R'(D'(dv_ctl.o0) + s0) : dv_ctl.o0;
    o1_d = dv_ctl.m1 ? R'(D'(dv_ctl.o1) + s1) : dv_ctl.o1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q   <= dv_ctl.c0;
      c1_q   <= dv_ctl.c1;
      o0_q   <= o0_d;
      o1_q   <= o1_d;
      rej_q  <= dv_ctl.rej;
      side_q <= dv_ctl.side;
    end
  end

  assign valid_o = c_valid_q;
  assign c0_o    = c0_q;
  assign c1_o    = c1_q;
  assign o0_o    = o0_q;
  assign o1_o    = o1_q;
  assign rej_o   = rej_q;
  assign side_o  = side_q;

endmodule

### bench/line_segment_window_clip_top_tb.sv
// Self-checking bench for line_segment_window_clip_top: directed and random segments
// against a predictor of the two-pass window clip. Depends on lswc_pkg and the top level.
module line_segment_window_clip_top_tb;
  import lswc_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int LATENCY = 2 * CB + 12;
  // index past the four registers, for the ignored-write check
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic          vis;
    logic [CB-1:0] sx, sy, ex, ey;
  } clip_res_t;

  typedef struct {
    logic [CB-1:0] sx, sy, ex, ey;
    logic          chk;     // expected result typed in
    clip_res_t     want;
  } seg_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CB-1:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [CB-1:0] sx_i, sy_i, ex_i, ey_i;
  logic out_valid, out_stall;
  logic vis_o;
  logic signed [CB-1:0] osx, osy, oex, oey;

  // window registers held by the predictor
  logic [CB-1:0] win_ox, win_oy;
  logic [CB-2:0] win_wx, win_wy;

  clip_res_t expected_q[$];
  int errors, seg_sent, seg_seen, visible_seen;
  bit idle_free, hold_out;

  line_segment_window_clip_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_x_i(sx_i), .start_y_i(sy_i), .end_x_i(ex_i), .end_y_i(ey_i),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .visible_o(vis_o), .out_start_x_o(osx), .out_start_y_o(osy),
    .out_end_x_o(oex), .out_end_y_o(oey)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // trunc(a * b / d); operands fit in 34 bits, the product in 68
  function automatic longint line_scale(longint a, longint b, longint d);
    logic signed [95:0] p;
    p = 96'(signed'(a)) * 96'(signed'(b));
    return longint'(p / 96'(signed'(d)));
  endfunction

  // clip c against [0, lim], slide o along the line; 0 when both lie past one side
  function automatic bit clip_pass(ref longint c0, ref longint o0, ref longint c1,
                                   ref longint o1, input longint lim);
    longint dc, dn;
    dc = c1 - c0;
    dn = o1 - o0;
    if (c0 < 0 && c1 < 0) return 0;
    if (c0 > lim && c1 > lim) return 0;
    if (c0 < 0) begin
      o0 += line_scale(dn, -c0, dc); c0 = 0;
    end else if (c0 > lim) begin
      o0 += line_scale(dn, lim - c0, dc); c0 = lim;
    end
    if (c1 > lim) begin
      o1 += line_scale(dn, lim - c1, dc); c1 = lim;
    end else if (c1 < 0) begin
      o1 += line_scale(dn, -c1, dc); c1 = 0;
    end
    return 1;
  endfunction

  function automatic clip_res_t clip_segment(logic [CB-1:0] sx, sy, ex, ey);
    clip_res_t r;
    longint ox, oy, ax, ay, bx, by;
    bit vis;
    ox = longint'(signed'(win_ox));
    oy = longint'(signed'(win_oy));
    ax = longint'(signed'(sx)) - ox;
    ay = longint'(signed'(sy)) - oy;
    bx = longint'(signed'(ex)) - ox;
    by = longint'(signed'(ey)) - oy;
    vis = clip_pass(ax, ay, bx, by, longint'(win_wx));
    if (vis) vis = clip_pass(ay, ax, by, bx, longint'(win_wy));
    r.vis = vis;
    if (vis) begin
      r.sx = CB'(ax + ox); r.sy = CB'(ay + oy);
      r.ex = CB'(bx + ox); r.ey = CB'(by + oy);
    end else begin
      r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h want %h", seg_seen, what, got, want);
  endtask

  // Drive a register write at a clock edge; mirror it in the predictor.
  // The caller drops the write enable after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CB-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X: win_ox = val;
      CFG_ORIGIN_Y: win_oy = val;
      CFG_EXTENT_X: win_wx = val[CB-2:0];
      CFG_EXTENT_Y: win_wy = val[CB-2:0];
      default: ;
    endcase
  endtask

  task automatic set_window(logic [CB-1:0] ox, oy, wx, wy);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_EXTENT_X, wx);
    write_reg(CFG_EXTENT_Y, wy);
    cfg_we <= 1'b0;
  endtask

  // Wait until all results are in, then let the pipeline drain before touching registers.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one request; hold it stable until accepted. Random idle gaps precede it.
  task automatic send_segment(logic [CB-1:0] sx, sy, ex, ey, bit chk, clip_res_t want);
    clip_res_t pred;
    while (!idle_free && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sx_i <= sx; sy_i <= sy; ex_i <= ex; ey_i <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = clip_segment(sx, sy, ex, ey);
    if (chk && pred != want) begin
      errors++;
      $display("table row %0d disagrees with the clip predictor", seg_sent);
    end
    expected_q.push_back(chk ? want : pred);
    seg_sent++;
  endtask

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'({$urandom(), $urandom()});
      1: return CB'($urandom_range(8000)) - CB'(2000) + win_ox;
      default: return CB'($urandom_range(8000)) - CB'(2000) + win_oy;
    endcase
  endfunction

  // Mostly segments near the window, some anywhere in the full range.
  task automatic random_segments(int n);
    clip_res_t none;
    int m;
    none = '0;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(99) < 80) ? 1 : 0;
      send_segment(rand_coord(m), rand_coord(m ? 2 : 0), rand_coord(m),
                   rand_coord(m ? 2 : 0), 1'b0, none);
    end
  endtask

  // Receiver side: random stalls, plus one long hold-off requested by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_out || (!idle_free && $urandom_range(99) < 11);
  end

  initial begin
    int hold_cnt;
    hold_out = 0;
    wait (seg_sent == 400);
    hold_out = 1;
    for (hold_cnt = 0; hold_cnt < 3 * LATENCY; hold_cnt++) @(posedge clk);
    hold_out = 0;
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    clip_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d", seg_seen);
      end else begin
        w = expected_q.pop_front();
        if (vis_o !== w.vis) report_mismatch("visible", CB'(vis_o), CB'(w.vis));
        if (osx !== w.sx) report_mismatch("out_start_x", osx, w.sx);
        if (osy !== w.sy) report_mismatch("out_start_y", osy, w.sy);
        if (oex !== w.ex) report_mismatch("out_end_x", oex, w.ex);
        if (oey !== w.ey) report_mismatch("out_end_y", oey, w.ey);
        if (w.vis) visible_seen++;
      end
      seg_seen++;
    end
  end

  initial begin
    #60000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    seg_row_t rows[$];
    logic [CB-1:0] mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    rst_n = 0; cfg_we = 0; cfg_idx = '0; cfg_data = '0; in_valid = 0;
    sx_i = '0; sy_i = '0; ex_i = '0; ey_i = '0;
    errors = 0; seg_sent = 0; seg_seen = 0; visible_seen = 0; idle_free = 0;
    win_ox = '0; win_oy = '0; win_wx = '0; win_wy = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // After reset the window is the single point at the origin.
    rows.push_back('{'0, '0, '0, '0, 1, '{1, '0, '0, '0, '0}});
    rows.push_back('{mn, mn, mx, mx, 1, '{1, '0, '0, '0, '0}});
    rows.push_back('{mn, 5, -1, 7, 1, '{0, mn, 5, -1, 7}});
    foreach (rows[i]) send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey,
                                   rows[i].chk, rows[i].want);
    drain_pipe();

    // Directed window: origin (256,256), extent 1024 x 512.
    write_reg(CFG_IDX_SPARE, 32'hdead_beef);   // unused index: must be ignored
    set_window(256, 256, 1024, 512);
    rows.delete();
    rows.push_back('{100, 100, 50, 900, 1, '{0, 100, 100, 50, 900}});      // left of window
    rows.push_back('{2000, 300, 1500, 400, 1, '{0, 2000, 300, 1500, 400}}); // right
    rows.push_back('{300, 10, 900, 100, 1, '{0, 300, 10, 900, 100}});      // above
    rows.push_back('{300, 900, 900, 1000, 1, '{0, 300, 900, 900, 1000}});  // below
    rows.push_back('{400, 400, 600, 500, 1, '{1, 400, 400, 600, 500}});    // inside
    rows.push_back('{0, 500, 2000, 500, 0, '{0, 0, 0, 0, 0}});             // horizontal
    rows.push_back('{700, 0, 700, 2000, 0, '{0, 0, 0, 0, 0}});             // vertical
    rows.push_back('{0, 0, 2000, 2000, 0, '{0, 0, 0, 0, 0}});              // diagonal
    rows.push_back('{2000, 2000, 0, 0, 0, '{0, 0, 0, 0, 0}});
    rows.push_back('{0, 900, 2000, 0, 0, '{0, 0, 0, 0, 0}});
    rows.push_back('{mn, mn, mx, mx, 0, '{0, 0, 0, 0, 0}});
    rows.push_back('{mx, mn, mn, mx, 0, '{0, 0, 0, 0, 0}});
    rows.push_back('{mn, 300, mx, 301, 0, '{0, 0, 0, 0, 0}});
    rows.push_back('{1280, 768, 256, 256, 1, '{1, 1280, 768, 256, 256}});  // corners
    foreach (rows[i]) send_segment(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey,
                                   rows[i].chk, rows[i].want);

    random_segments(450);
    drain_pipe();

    // Extreme window: most negative origin, full extent.
    set_window(mn, mn, mx, mx);
    idle_free = 1;                    // a stretch with no idling on either side
    random_segments(300);
    idle_free = 0;
    drain_pipe();

    set_window(mx, 32'hffff_f000, 0, 37);
    random_segments(200);
    drain_pipe();

    set_window({$urandom()}, {$urandom()}, $urandom_range(4000), $urandom_range(4000));
    random_segments(380);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Covered %0d segments over five window settings, %0d of them visible.",
             seg_seen, visible_seen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
